// ===== rtl/ptra_pkg.sv =====
// Shared types and constants for the page table run allocator.
package ptra_pkg;

   localparam int FuncWidth   = 3;
   localparam int PageWidth   = 36;
   localparam int CountWidth  = 13;
   localparam int TypeWidth   = 5;
   localparam int LimitWidth  = 16;
   localparam int AddrWidth   = 48;
   localparam int CsrIdxWidth = 2;

   localparam logic [TypeWidth-1:0] TypeFwPermanent = 5'd6;

   localparam logic [FuncWidth-1:0] FuncMark      = 3'd0;
   localparam logic [FuncWidth-1:0] FuncAlloc     = 3'd1;
   localparam logic [FuncWidth-1:0] FuncFree      = 3'd2;
   localparam logic [FuncWidth-1:0] FuncFind      = 3'd3;
   localparam logic [FuncWidth-1:0] FuncFindBelow = 3'd4;
   localparam logic [FuncWidth-1:0] FuncCheck     = 3'd5;

   localparam logic [CsrIdxWidth-1:0] CsrLowestPage = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrTotalPages = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrFreeType   = 2'd2;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SETUP = 6'b000100,
      ST_WALK  = 6'b001000,
      ST_PIPE  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

endpackage

// ===== rtl/page_table_run_allocator.sv =====
// Top level of the page table run allocator: sequencer, page table memory and streams.
//
// Usage: one request transfer on req_ (func, start_page, page_count, mem_type,
// from_end, limit_index, address) gives exactly one response transfer on rsp_
// (status, found_page, available). Registers lowest_page, total_pages, free_type
// are written on csr_; the user must do so only while idle; the block does not check.
//
// Each request walks the page table one entry per cycle through a single
// memory port that either reads or writes. A request passes through setup,
// the walk over its entries, a drain state after reads, and the response.
// One request is in flight at a time; req_tready is low while it is processed.
//
// After reset the table is swept once, one entry per cycle, setting every
// page to the firmware-permanent type; no request is taken during the sweep
// (CSR writes are still accepted).
//
// The response sits in an output register until rsp_tready takes it; a
// stalled receiver holds the block, and the next request is taken only once
// the response has gone.
module page_table_run_allocator
   import ptra_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // func[2:0], start_page[38:3], page_count[51:39], mem_type[56:52],
   // from_end[57], limit_index[73:58], address[121:74], zero fill to 128
   input  logic [127:0]           req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[0], found_page[36:1], available[37], zero fill to 40
   output logic [39:0]            rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [PageWidth-1:0]   csr_data
);

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int NW   = IdxW + 1;
   localparam logic [NW-1:0] DepthN = NW'(TABLE_DEPTH);
   // wide enough for the page of a byte address at a page shift of 8 or more
   localparam int PgW  = PageWidth + 4;

   // request fields
   logic [FuncWidth-1:0]  f_func;
   logic [PageWidth-1:0]  f_start;
   logic [CountWidth-1:0] f_count;
   logic [TypeWidth-1:0]  f_type;
   logic                  f_from_end;
   logic [LimitWidth-1:0] f_limit;
   logic [AddrWidth-1:0]  f_addr;
   assign f_func     = req_tdata[2:0];
   assign f_start    = req_tdata[38:3];
   assign f_count    = req_tdata[51:39];
   assign f_type     = req_tdata[56:52];
   assign f_from_end = req_tdata[57];
   assign f_limit    = req_tdata[73:58];
   assign f_addr     = req_tdata[121:74];

   // configuration
   logic [PageWidth-1:0]  lowest_ff;
   logic [CountWidth-1:0] total_ff;
   logic [TypeWidth-1:0]  ftype_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff <= '0;
         total_ff  <= 13'd4096;
         ftype_ff  <= 5'd2;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrLowestPage: lowest_ff <= csr_data;
            CsrTotalPages: total_ff  <= csr_data[CountWidth-1:0];
            CsrFreeType:   ftype_ff  <= csr_data[TypeWidth-1:0];
            default: ;
         endcase
      end
   end

   // window size n = min(total_pages, TABLE_DEPTH), NW bits wide
   logic [NW-1:0] win_n;
   always_comb begin
      if (32'(total_ff) >= 32'(TABLE_DEPTH))
         win_n = DepthN;
      else
         win_n = NW'(total_ff);
   end

   // page table memory: type and allocation length per entry
   logic [TypeWidth-1:0]  type_mem [TABLE_DEPTH];
   logic [CountWidth-1:0] len_mem  [TABLE_DEPTH];
   logic                  mem_we;
   logic [IdxW-1:0]       mem_addr;
   logic [TypeWidth-1:0]  mem_wtype;
   logic [CountWidth-1:0] mem_wlen;
   logic [TypeWidth-1:0]  mem_rtype_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         type_mem[mem_addr] <= mem_wtype;
         len_mem[mem_addr]  <= mem_wlen;
      end
      mem_rtype_ff <= type_mem[mem_addr];
   end

   // sequencer registers
   state_type             state_ff, state_in;
   logic [FuncWidth-1:0]  func_ff, func_in;
   logic [CountWidth-1:0] need_ff, need_in;
   logic [TypeWidth-1:0]  wtype_ff, wtype_in;
   logic                  down_ff, down_in;
   logic [NW-1:0]         idx_ff, idx_in;      // current entry
   logic [NW-1:0]         left_ff, left_in;    // entries still to visit
   logic                  first_ff, first_in;  // first entry of a write range
   logic [NW:0]           have_ff, have_in;    // free run length so far
   logic [NW-1:0]         pidx_ff, pidx_in;    // index whose read data is due
   logic                  pval_ff, pval_in;
   logic                  status_ff, status_in;
   logic [PageWidth-1:0]  found_ff, found_in;
   logic                  avail_ff, avail_in;
   logic                  done_ff, done_in;    // search settled early

   // setup arithmetic (one wide subtract and compare each)
   logic [PgW-1:0] pg_abs;
   logic           below;
   logic [PgW-1:0] rel;
   logic [PgW:0]   rel_end;
   logic           is_write, is_search;
   assign pg_abs  = (f_func == FuncCheck) ? PgW'(f_addr >> PAGE_SHIFT) : PgW'(f_start);
   assign below   = pg_abs < PgW'(lowest_ff);
   assign rel     = pg_abs - PgW'(lowest_ff);
   assign rel_end = {1'b0, rel} + (PgW+1)'(f_count);
   assign is_write = (func_ff == FuncMark) || (func_ff == FuncAlloc) ||
                     (func_ff == FuncFree);
   assign is_search = (func_ff == FuncFind) || (func_ff == FuncFindBelow);

   // walk helpers
   logic            rd_free;
   logic [NW:0]     have_next;
   logic [PageWidth-1:0] hit_page;
   assign rd_free   = mem_rtype_ff == ftype_ff;
   assign have_next = rd_free ? have_ff + 1'b1 : '0;
   always_comb begin
      if (down_ff)
         hit_page = lowest_ff + PageWidth'(pidx_ff);
      else
         hit_page = lowest_ff + PageWidth'(pidx_ff) - PageWidth'(have_next) + 1'b1;
   end

   assign req_tready = state_ff == ST_IDLE;
   assign rsp_tvalid = state_ff == ST_RESP;
   assign rsp_tdata  = {2'b00, avail_ff, found_ff, status_ff};

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      need_in   = need_ff;
      wtype_in  = wtype_ff;
      down_in   = down_ff;
      idx_in    = idx_ff;
      left_in   = left_ff;
      first_in  = first_ff;
      have_in   = have_ff;
      pidx_in   = pidx_ff;
      pval_in   = 1'b0;
      status_in = status_ff;
      found_in  = found_ff;
      avail_in  = avail_ff;
      done_in   = done_ff;
      mem_we    = 1'b0;
      mem_addr  = idx_ff[IdxW-1:0];
      mem_wtype = wtype_ff;
      mem_wlen  = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_wtype = TypeFwPermanent;
            mem_wlen  = CountWidth'(1);
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == DepthN - 1'b1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in   = f_func;
               need_in   = f_count;
               down_in   = f_from_end;
               status_in = 1'b0;
               found_in  = '0;
               avail_in  = 1'b0;
               done_in   = 1'b0;
               have_in   = '0;
               first_in  = 1'b1;
               left_in   = '0;
               idx_in    = '0;
               wtype_in  = f_type;
               state_in  = ST_SETUP;
               unique case (f_func)
                  FuncMark: begin
                     if (below || rel_end > (PgW+1)'(win_n)) status_in = 1'b1;
                     else begin
                        idx_in  = NW'(rel);
                        left_in = NW'(f_count);
                     end
                  end
                  FuncAlloc, FuncFree: begin
                     if (f_func == FuncFree) wtype_in = ftype_ff;
                     if (!below && rel < PgW'(win_n)) begin
                        idx_in = NW'(rel);
                        // clip to the window end
                        if (rel_end > (PgW+1)'(win_n))
                           left_in = win_n - NW'(rel);
                        else
                           left_in = NW'(f_count);
                     end
                  end
                  FuncFind: begin
                     if (f_from_end) begin
                        idx_in  = win_n - 1'b1;
                        left_in = (win_n > 1) ? win_n - 1'b1 : '0;
                     end else begin
                        idx_in  = NW'(1);
                        left_in = (win_n > 1) ? win_n - 1'b1 : '0;
                     end
                  end
                  FuncFindBelow: begin
                     down_in = 1'b1;
                     if (32'(f_limit) > 32'(win_n)) begin
                        idx_in  = win_n - 1'b1;
                        left_in = (win_n > 1) ? win_n - 1'b1 : '0;
                     end else if (f_limit > 0) begin
                        idx_in  = NW'(f_limit - 1'b1);
                        left_in = NW'(f_limit - 1'b1);
                     end
                  end
                  FuncCheck: begin
                     if (f_count == '0) avail_in = 1'b1;
                     else if (!below && rel_end <= (PgW+1)'(win_n)) begin
                        avail_in = 1'b1;
                        idx_in   = NW'(rel);
                        left_in  = NW'(f_count);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP: begin
            state_in = (left_ff == '0) ? ST_RESP : ST_WALK;
         end
         ST_WALK: begin
            // issue one access per cycle; read data returns in the following cycle
            if (is_write) begin
               mem_we   = 1'b1;
               if (func_ff == FuncMark)
                  mem_wlen = (wtype_ff != ftype_ff) ? CountWidth'(1) : '0;
               else if (func_ff == FuncAlloc && first_ff)
                  mem_wlen = need_ff;
            end else begin
               pval_in = 1'b1;
               pidx_in = idx_ff;
            end
            first_in = 1'b0;
            idx_in   = down_ff && is_search ? idx_ff - 1'b1 : idx_ff + 1'b1;
            left_in  = left_ff - 1'b1;
            if (left_ff == NW'(1)) state_in = is_write ? ST_RESP : ST_PIPE;
         end
         ST_PIPE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // evaluate read data that came back this cycle
      if (pval_ff && !done_ff) begin
         if (func_ff == FuncCheck) begin
            if (!rd_free) begin
               avail_in = 1'b0;
               done_in  = 1'b1;
            end
         end else begin
            have_in = have_next;
            if (rd_free && 32'(have_next) >= 32'(need_ff)) begin
               found_in = hit_page;
               done_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         pval_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pval_ff  <= pval_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      need_ff   <= need_in;
      wtype_ff  <= wtype_in;
      down_ff   <= down_in;
      left_ff   <= left_in;
      first_ff  <= first_in;
      have_ff   <= have_in;
      pidx_ff   <= pidx_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      avail_ff  <= avail_in;
   end

endmodule
